>>> sv/calu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calu_pkg
// Shared types and operation codes for the flag-producing CPU ALU.
// ----------------------------------------------------------------------------
package calu_pkg;

  // Operation codes
  typedef enum logic [5:0] {
    ACT_ADD    = 6'd0,
    ACT_ADC    = 6'd1,
    ACT_SUB    = 6'd2,
    ACT_SBC    = 6'd3,
    ACT_AND    = 6'd4,
    ACT_XOR    = 6'd5,
    ACT_OR     = 6'd6,
    ACT_CP     = 6'd7,
    ACT_INC    = 6'd8,
    ACT_DEC    = 6'd9,
    ACT_DAA    = 6'd10,
    ACT_CPL    = 6'd11,
    ACT_CCF    = 6'd12,
    ACT_SCF    = 6'd13,
    ACT_RLCA   = 6'd14,
    ACT_RLA    = 6'd15,
    ACT_RRCA   = 6'd16,
    ACT_RRA    = 6'd17,
    ACT_RLC    = 6'd18,
    ACT_RRC    = 6'd19,
    ACT_RL     = 6'd20,
    ACT_RR     = 6'd21,
    ACT_SLA    = 6'd22,
    ACT_SRA    = 6'd23,
    ACT_SRL    = 6'd24,
    ACT_SWAP   = 6'd25,
    ACT_BIT    = 6'd26,
    ACT_RES    = 6'd27,
    ACT_SET    = 6'd28,
    ACT_ADD16  = 6'd29,
    ACT_ADDSP  = 6'd30,
    ACT_INC16  = 6'd31,
    ACT_DEC16  = 6'd32
  } action_e;

  // Decimal adjust corrections
  localparam logic [7:0] DAA_HI_FIX = 8'h60;
  localparam logic [7:0] DAA_LO_FIX = 8'h06;
  localparam logic [7:0] DAA_HI_MAX = 8'h99;
  localparam logic [3:0] DAA_LO_MAX = 4'h9;

  // Request: one operation with operands and incoming flags
  typedef struct packed {
    logic [5:0]  action;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic        zero_in;
    logic        subtract_in;
    logic        half_in;
    logic        carry_in;
  } in_req_t;

  // Result: value and outgoing flags
  typedef struct packed {
    logic [15:0] value_out;
    logic        zero_out;
    logic        subtract_out;
    logic        half_out;
    logic        carry_out;
  } out_rsp_t;

endpackage

>>> sv/calu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calu_core
// Combinational datapath: computes value and flags for one request.
// ----------------------------------------------------------------------------
module calu_core (
  input  calu_pkg::in_req_t  req_i,
  output calu_pkg::out_rsp_t rsp_o
);
  import calu_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic        t;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  diff9;
  logic [4:0]  hdiff5;
  logic [7:0]  bmask;
  logic [7:0]  daa_v;
  logic        daa_c;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [15:0] spsum;
  logic [8:0]  spbyte;
  logic [4:0]  spnib;
  logic [7:0]  bv;
  logic [15:0] v;
  logic        z;
  logic        n;
  logic        h;
  logic        c;

  assign a   = req_i.operand_a[7:0];
  assign b   = req_i.operand_b[7:0];
  assign cin = req_i.carry_in;

  // Carry/borrow in only for the with-carry forms
  assign t = ((req_i.action == ACT_ADC) || (req_i.action == ACT_SBC)) ? cin : 1'b0;

  // Byte adder and subtractor with nibble carries
  assign sum9   = {1'b0, a} + {1'b0, b} + {8'h00, t};
  assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t};
  assign diff9  = {1'b0, a} - {1'b0, b} - {8'h00, t};
  assign hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, t};

  // One-hot mask for bit test, reset and set
  assign bmask = 8'h01 << req_i.bit_index;

  // Decimal adjust after add or subtract
  always_comb begin
    daa_v = a;
    daa_c = cin;
    if (!req_i.subtract_in) begin
      if (cin || (a > DAA_HI_MAX)) begin
        daa_v = daa_v + DAA_HI_FIX;
        daa_c = 1'b1;
      end
      if (req_i.half_in || (a[3:0] > DAA_LO_MAX)) begin
        daa_v = daa_v + DAA_LO_FIX;
      end
    end else begin
      if (cin) begin
        daa_v = daa_v - DAA_HI_FIX;
      end
      if (req_i.half_in) begin
        daa_v = daa_v - DAA_LO_FIX;
      end
    end
  end

  // Word adds: HL + rr and SP + signed offset
  assign sum17  = {1'b0, req_i.operand_a} + {1'b0, req_i.operand_b};
  assign sum13  = {1'b0, req_i.operand_a[11:0]} + {1'b0, req_i.operand_b[11:0]};
  assign spsum  = req_i.operand_a + {{8{b[7]}}, b};
  assign spbyte = {1'b0, req_i.operand_a[7:0]} + {1'b0, b};
  assign spnib  = {1'b0, req_i.operand_a[3:0]} + {1'b0, b[3:0]};

  // Operation select; untouched flags pass through
  always_comb begin
    bv = a;
    v  = req_i.operand_a;
    z  = req_i.zero_in;
    n  = req_i.subtract_in;
    h  = req_i.half_in;
    c  = cin;
    case (req_i.action)
      ACT_ADD, ACT_ADC: begin
        bv = sum9[7:0]; v = {8'h00, bv};
        z = (bv == 8'h00); n = 1'b0; h = hsum5[4]; c = sum9[8];
      end
      ACT_SUB, ACT_SBC, ACT_CP: begin
        bv = (req_i.action == ACT_CP) ? a : diff9[7:0];
        v = {8'h00, bv};
        z = (diff9[7:0] == 8'h00); n = 1'b1; h = hdiff5[4]; c = diff9[8];
      end
      ACT_AND: begin
        bv = a & b; v = {8'h00, bv};
        z = (bv == 8'h00); n = 1'b0; h = 1'b1; c = 1'b0;
      end
      ACT_XOR: begin
        bv = a ^ b; v = {8'h00, bv};
        z = (bv == 8'h00); n = 1'b0; h = 1'b0; c = 1'b0;
      end
      ACT_OR: begin
        bv = a | b; v = {8'h00, bv};
        z = (bv == 8'h00); n = 1'b0; h = 1'b0; c = 1'b0;
      end
      ACT_INC: begin
        bv = a + 8'h01; v = {8'h00, bv};
        z = (bv == 8'h00); n = 1'b0; h = (a[3:0] == 4'hF);
      end
      ACT_DEC: begin
        bv = a - 8'h01; v = {8'h00, bv};
        z = (bv == 8'h00); n = 1'b1; h = (a[3:0] == 4'h0);
      end
      ACT_DAA: begin
        bv = daa_v; v = {8'h00, bv};
        z = (bv == 8'h00); h = 1'b0; c = daa_c;
      end
      ACT_CPL: begin
        bv = ~a; v = {8'h00, bv}; n = 1'b1; h = 1'b1;
      end
      ACT_CCF: begin
        v = {8'h00, a}; n = 1'b0; h = 1'b0; c = ~cin;
      end
      ACT_SCF: begin
        v = {8'h00, a}; n = 1'b0; h = 1'b0; c = 1'b1;
      end
      // Accumulator rotates always clear Z
      ACT_RLCA: begin
        v = {8'h00, a[6:0], a[7]}; z = 1'b0; n = 1'b0; h = 1'b0; c = a[7];
      end
      ACT_RLA: begin
        v = {8'h00, a[6:0], cin}; z = 1'b0; n = 1'b0; h = 1'b0; c = a[7];
      end
      ACT_RRCA: begin
        v = {8'h00, a[0], a[7:1]}; z = 1'b0; n = 1'b0; h = 1'b0; c = a[0];
      end
      ACT_RRA: begin
        v = {8'h00, cin, a[7:1]}; z = 1'b0; n = 1'b0; h = 1'b0; c = a[0];
      end
      // Prefixed rotates and shifts take Z from the result
      ACT_RLC: begin
        bv = {a[6:0], a[7]}; v = {8'h00, bv};
        z = (bv == 8'h00); n = 1'b0; h = 1'b0; c = a[7];
      end
      ACT_RRC: begin
        bv = {a[0], a[7:1]}; v = {8'h00, bv};
        z = (bv == 8'h00); n = 1'b0; h = 1'b0; c = a[0];
      end
      ACT_RL: begin
        bv = {a[6:0], cin}; v = {8'h00, bv};
        z = (bv == 8'h00); n = 1'b0; h = 1'b0; c = a[7];
      end
      ACT_RR: begin
        bv = {cin, a[7:1]}; v = {8'h00, bv};
        z = (bv == 8'h00); n = 1'b0; h = 1'b0; c = a[0];
      end
      ACT_SLA: begin
        bv = {a[6:0], 1'b0}; v = {8'h00, bv};
        z = (bv == 8'h00); n = 1'b0; h = 1'b0; c = a[7];
      end
      ACT_SRA: begin
        bv = {a[7], a[7:1]}; v = {8'h00, bv};
        z = (bv == 8'h00); n = 1'b0; h = 1'b0; c = a[0];
      end
      ACT_SRL: begin
        bv = {1'b0, a[7:1]}; v = {8'h00, bv};
        z = (bv == 8'h00); n = 1'b0; h = 1'b0; c = a[0];
      end
      ACT_SWAP: begin
        bv = {a[3:0], a[7:4]}; v = {8'h00, bv};
        z = (bv == 8'h00); n = 1'b0; h = 1'b0; c = 1'b0;
      end
      ACT_BIT: begin
        v = {8'h00, a}; z = ((a & bmask) == 8'h00); n = 1'b0; h = 1'b1;
      end
      ACT_RES: begin
        v = {8'h00, a & ~bmask};
      end
      ACT_SET: begin
        v = {8'h00, a | bmask};
      end
      // H from bit 11 carry, C from bit 15 carry, Z kept
      ACT_ADD16: begin
        v = sum17[15:0]; n = 1'b0; h = sum13[12]; c = sum17[16];
      end
      ACT_ADDSP: begin
        v = spsum; z = 1'b0; n = 1'b0; h = spnib[4]; c = spbyte[8];
      end
      ACT_INC16: begin
        v = req_i.operand_a + 16'h0001;
      end
      ACT_DEC16: begin
        v = req_i.operand_a - 16'h0001;
      end
      default: begin
        v = req_i.operand_a;
      end
    endcase
  end

  assign rsp_o.value_out    = v;
  assign rsp_o.zero_out     = z;
  assign rsp_o.subtract_out = n;
  assign rsp_o.half_out     = h;
  assign rsp_o.carry_out    = c;

endmodule

>>> sv/cpu_alu_with_flags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_alu_with_flags
// Flag-producing ALU of an 8-bit handheld CPU. A request carries an
// operation, two operands, a bit index and the current Z/N/H/C flags; the
// response carries the new value and flags. Every operation passes the input
// register and then the result register, with only the single-pass ALU
// datapath between them. One request is accepted every cycle while the
// output side does not stall; a stall on the output backs up through both
// registers, so in_stall_o follows out_stall_i once both stages hold a
// request.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  calu_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output calu_pkg::out_rsp_t out_rsp_o
);
  import calu_pkg::*;

  logic     s1_valid_q, s1_valid_d;
  in_req_t  s1_req_q;
  logic     s2_valid_q, s2_valid_d;
  out_rsp_t s2_rsp_q;
  out_rsp_t core_rsp;
  logic     s2_ready;
  logic     s1_ready;
  logic     in_take;
  logic     s1_move;

  // Stage readiness
  assign s2_ready = !s2_valid_q || !out_stall_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign in_take  = in_valid_i && s1_ready;
  assign s1_move  = s1_valid_q && s2_ready;

  assign s1_valid_d = in_take || (s1_valid_q && !s2_ready);
  assign s2_valid_d = s1_move || (s2_valid_q && out_stall_i);

  // ALU datapath
  calu_core u_core (
    .req_i (s1_req_q),
    .rsp_o (core_rsp)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_req_q <= in_req_i;
    end
    if (s1_move) begin
      s2_rsp_q <= core_rsp;
    end
  end

  assign in_stall_o  = !s1_ready;
  assign out_valid_o = s2_valid_q;
  assign out_rsp_o   = s2_rsp_q;

  // A stall at the input only happens with both stages full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q))
    else $error("input stalled with a free stage");

  // A request held in stage one while the output stalls is not dropped
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && out_stall_i) |=> s1_valid_q)
    else $error("request lost in stage one");

  // A request in stage one with an empty output stage appears next cycle
  a_s1_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_valid_q) |=> s2_valid_q)
    else $error("request did not reach the output register");

  // Byte operations never produce a high byte
  a_byte_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (s1_req_q.action <= ACT_SET)) |-> (core_rsp.value_out[15:8] == 8'h00))
    else $error("byte operation with nonzero high byte");

endmodule
